// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of i_clk, skipped while i_rst_n is low.
`define BMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication checked on every rising edge of i_clk.
`define BMP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/bmp565_pkg.sv =====
// Types and constants for the BMP to RGB565 pixel decoder.
package bmp565_pkg;

    // Header byte positions
    localparam logic [31:0] POS_OFFSET_B0 = 32'd10;
    localparam logic [31:0] POS_OFFSET_B3 = 32'd13;
    localparam logic [31:0] POS_WIDTH_LO  = 32'd18;
    localparam logic [31:0] POS_WIDTH_HI  = 32'd19;
    localparam logic [31:0] POS_HEIGHT_LO = 32'd22;
    localparam logic [31:0] POS_HEIGHT_HI = 32'd23;
    localparam logic [31:0] POS_DEPTH     = 32'd28;

    localparam logic [7:0]  DEPTH_24   = 8'd24;
    localparam logic [31:0] MIN_OFFSET = 32'd29;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        EV_PIXEL  = 2'd0,
        EV_END    = 2'd1,
        EV_REJECT = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_byte_beat;

    typedef struct packed {
        t_event      event_res;
        logic [16:0] pixel_x;
        logic [16:0] pixel_y;
        logic [15:0] color;
        logic        final_res;
    } t_pix_beat;

    // Command passed from the parser to the pixel back end
    typedef struct packed {
        t_event      event_res;
        logic [15:0] column;
        logic [16:0] row_offset;   // height - 1 - file row, mod 2^17
        logic [15:0] color;
        logic        final_res;
    } t_pix_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== sv/bmp565_if.sv =====
// Valid/ready stream interfaces for file bytes and pixel results.
interface bmp565_byte_if import bmp565_pkg::*; ();
    logic       valid;
    logic       ready;
    t_byte_beat payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface bmp565_pix_if import bmp565_pkg::*; ();
    logic      valid;
    logic      ready;
    t_pix_beat payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== sv/bmp565_front.sv =====
// Byte parser: header capture, row walk, triple assembly into pixel commands, and end or reject commands.
module bmp565_front import bmp565_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmp565_byte_if.sink i_byte,
    input  t_q_status i_q_stat,
    output logic      o_push,
    output t_pix_cmd  o_cmd
);

    logic [31:0] r_byte_pos,    n_byte_pos;
    logic [31:0] r_data_offset, n_data_offset;
    logic [15:0] r_image_width, n_image_width;
    logic [15:0] r_image_height, n_image_height;
    logic [17:0] r_byte_in_row, n_byte_in_row;
    logic [15:0] r_file_row,    n_file_row;
    logic [15:0] r_pixel_column, n_pixel_column;
    logic [15:0] r_held_bg,     n_held_bg;
    t_phase      r_triple_phase, n_triple_phase;
    logic        r_rejected,    n_rejected;
    logic [17:0] r_pix_bytes;
    logic [17:0] r_row_bytes;

    logic        beat;
    logic        emit;
    t_pix_cmd    cmd;
    logic [7:0]  b;
    logic [1:0]  off_lane;
    logic [17:0] row_inc;

    assign i_byte.ready = !i_q_stat.full;
    assign beat         = i_byte.valid && i_byte.ready;
    assign b            = i_byte.payload.file_byte;
    assign off_lane     = r_byte_pos[1:0] - POS_OFFSET_B0[1:0];
    assign row_inc      = r_byte_in_row + 18'd1;

    always_comb begin
        n_byte_pos     = r_byte_pos;
        n_data_offset  = r_data_offset;
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_byte_in_row  = r_byte_in_row;
        n_file_row     = r_file_row;
        n_pixel_column = r_pixel_column;
        n_held_bg      = r_held_bg;
        n_triple_phase = r_triple_phase;
        n_rejected     = r_rejected;
        emit           = 1'b0;
        cmd            = '0;

        if (!r_rejected) begin
            if (r_byte_pos <= POS_DEPTH) begin
                if (r_byte_pos inside {[POS_OFFSET_B0:POS_OFFSET_B3]}) begin
                    n_data_offset[{off_lane, 3'b000} +: 8] = b;
                end
                if (r_byte_pos == POS_WIDTH_LO) begin
                    n_image_width[7:0] = b;
                end
                if (r_byte_pos == POS_WIDTH_HI) begin
                    n_image_width[15:8] = b;
                end
                if (r_byte_pos == POS_HEIGHT_LO) begin
                    n_image_height[7:0] = b;
                end
                if (r_byte_pos == POS_HEIGHT_HI) begin
                    n_image_height[15:8] = b;
                end
                if (r_byte_pos == POS_DEPTH) begin
                    if (b != DEPTH_24 || r_data_offset < MIN_OFFSET) begin
                        n_rejected    = 1'b1;
                        emit          = 1'b1;
                        cmd.event_res = EV_REJECT;
                        cmd.final_res = 1'b1;
                    end
                end
            end else if (r_byte_pos >= r_data_offset && r_file_row < r_image_height) begin
                if (r_byte_in_row < r_pix_bytes) begin
                    case (r_triple_phase)
                        PH_BLUE: begin
                            n_held_bg      = {8'h00, b};
                            n_triple_phase = PH_GREEN;
                        end
                        PH_GREEN: begin
                            n_held_bg[15:8] = b;
                            n_triple_phase  = PH_RED;
                        end
                        PH_RED: begin
                            emit           = 1'b1;
                            cmd.event_res  = EV_PIXEL;
                            cmd.column     = r_pixel_column;
                            cmd.row_offset = 17'(r_image_height) - 17'd1
                                             - 17'(r_file_row);
                            cmd.color      = {b[7:3], r_held_bg[15:10], r_held_bg[7:3]};
                            n_triple_phase = PH_BLUE;
                            n_pixel_column = r_pixel_column + 16'd1;
                        end
                        default: begin
                            n_triple_phase = PH_BLUE;
                        end
                    endcase
                end
                if (row_inc >= r_row_bytes) begin
                    n_byte_in_row  = '0;
                    n_triple_phase = PH_BLUE;
                    n_pixel_column = '0;
                    n_file_row     = r_file_row + 16'd1;
                end else begin
                    n_byte_in_row = row_inc;
                end
            end
        end

        if (r_byte_pos != '1) begin
            n_byte_pos = r_byte_pos + 32'd1;
        end

        if (i_byte.payload.end_of_file) begin
            if (emit) begin
                cmd.final_res = 1'b1;
            end else if (!n_rejected) begin
                emit          = 1'b1;
                cmd.event_res = (r_byte_pos < POS_DEPTH) ? EV_REJECT : EV_END;
                cmd.final_res = 1'b1;
            end
            n_byte_pos     = '0;
            n_data_offset  = '0;
            n_image_width  = '0;
            n_image_height = '0;
            n_byte_in_row  = '0;
            n_file_row     = '0;
            n_pixel_column = '0;
            n_held_bg      = '0;
            n_triple_phase = PH_BLUE;
            n_rejected     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= '0;
            r_data_offset  <= '0;
            r_image_width  <= '0;
            r_image_height <= '0;
            r_byte_in_row  <= '0;
            r_file_row     <= '0;
            r_pixel_column <= '0;
            r_held_bg      <= '0;
            r_triple_phase <= PH_BLUE;
            r_rejected     <= 1'b0;
        end else if (beat) begin
            r_byte_pos     <= n_byte_pos;
            r_data_offset  <= n_data_offset;
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_byte_in_row  <= n_byte_in_row;
            r_file_row     <= n_file_row;
            r_pixel_column <= n_pixel_column;
            r_held_bg      <= n_held_bg;
            r_triple_phase <= n_triple_phase;
            r_rejected     <= n_rejected;
        end
    end

    // Row geometry follows the width; it settles long before the pixel data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_bytes <= '0;
            r_row_bytes <= '0;
        end else begin
            r_pix_bytes <= {1'b0, r_image_width, 1'b0} + 18'(r_image_width);
            r_row_bytes <= (r_pix_bytes + 18'd3) & ~18'd3;
        end
    end

    assign o_push = beat && emit;
    assign o_cmd  = cmd;

endmodule

// ===== sv/bmp565_queue.sv =====
// Small command FIFO between the parser and the pixel back end.
module bmp565_queue import bmp565_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pix_cmd  i_cmd,
    input  logic      i_pop,
    output t_pix_cmd  o_head,
    output t_q_status o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pix_cmd         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/bmp565_back.sv =====
// Pixel back end: screen coordinates and the registered output beat.
module bmp565_back import bmp565_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_origin_x,
    input  logic [CFG_DATA_W-1:0] i_origin_y,
    input  t_pix_cmd              i_head,
    input  t_q_status             i_q_stat,
    output logic                  o_pop,
    bmp565_pix_if.source          o_pix
);

    logic      r_valid;
    t_pix_beat r_beat;
    t_pix_beat n_beat;

    assign o_pop = !i_q_stat.empty && (!r_valid || o_pix.ready);

    always_comb begin
        n_beat           = '0;
        n_beat.event_res = i_head.event_res;
        n_beat.final_res = i_head.final_res;
        if (i_head.event_res == EV_PIXEL) begin
            n_beat.pixel_x = 17'(i_origin_x) + 17'(i_head.column);
            n_beat.pixel_y = 17'(i_origin_y) + i_head.row_offset;
            n_beat.color   = i_head.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= n_beat;
        end
    end

    assign o_pix.valid   = r_valid;
    assign o_pix.payload = r_beat;

endmodule

// ===== sv/bmp24_stream_to_rgb565_pixels.sv =====
// Throughput: one file byte per cycle unless the queue is full; parser state updates
// once per accepted beat; a command goes into the queue and then the output register.
// The command queue parts parser and output register, so each side stalls on its own.
// Reset: synchronous active-low; clears parser, queue, output valid and origins to zero.
`include "assert_macros.svh"

module bmp24_stream_to_rgb565_pixels import bmp565_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmp565_byte_if.sink           i_byte,
    bmp565_pix_if.source          o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_origin_x;
    logic [CFG_DATA_W-1:0] r_origin_y;

    logic      push;
    logic      pop;
    t_pix_cmd  cmd;
    t_pix_cmd  head;
    t_q_status q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_wdata;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bmp565_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    bmp565_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    bmp565_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_pix      (o_pix)
    );

    `BMP_ASSERT(a_queue_state, !(q_stat.full && q_stat.empty), "queue full and empty")
    `BMP_ASSERT_IMPL(a_end_is_final, push && cmd.event_res != EV_PIXEL, cmd.final_res, "end or reject not final")
    `BMP_ASSERT_IMPL(a_push_has_room, push, !q_stat.full, "push into full queue")
    `BMP_ASSERT_IMPL(a_nonpixel_zero, o_pix.valid && o_pix.payload.event_res != EV_PIXEL, o_pix.payload.pixel_x == 17'd0 && o_pix.payload.pixel_y == 17'd0 && o_pix.payload.color == 16'd0, "non-pixel beat has coordinates")

endmodule

// ===== tb/bmp24_stream_to_rgb565_pixels_checker.sv =====
// Decodes the observed BMP byte stream on its own and checks every result beat of the decoder.
module bmp24_stream_to_rgb565_pixels_checker import bmp565_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmp565_byte_if                i_byte,
    bmp565_pix_if                 i_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    logic [10:0] org_x;
    logic [10:0] org_y;

    logic [31:0] file_pos;
    logic [31:0] pixel_base;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [17:0] row_pos;
    logic [15:0] row_num;
    logic [15:0] col_num;
    logic [15:0] blue_green;
    t_phase      rgb_phase;
    logic        rejected_f;

    t_pix_beat   predicted_pix_beats[$];
    int          mismatches = 0;

    task automatic restart_file();
        file_pos   = '0;
        pixel_base = '0;
        img_w      = '0;
        img_h      = '0;
        row_pos    = '0;
        row_num    = '0;
        col_num    = '0;
        blue_green = '0;
        rgb_phase  = PH_BLUE;
        rejected_f = 1'b0;
    endtask

    task automatic decode_file_byte(input logic [7:0] b, input logic eof);
        logic [31:0] pos;
        logic [31:0] pix_bytes;
        logic [31:0] row_bytes;
        logic        hit;
        t_pix_beat   res;
        pos = file_pos;
        hit = 1'b0;
        res = '0;
        if (!rejected_f) begin
            if (pos <= POS_DEPTH) begin
                if (pos >= POS_OFFSET_B0 && pos <= POS_OFFSET_B3)
                    pixel_base = pixel_base | (32'(b) << (8 * (pos - POS_OFFSET_B0)));
                else if (pos == POS_WIDTH_LO)
                    img_w[7:0] = b;
                else if (pos == POS_WIDTH_HI)
                    img_w[15:8] = b;
                else if (pos == POS_HEIGHT_LO)
                    img_h[7:0] = b;
                else if (pos == POS_HEIGHT_HI)
                    img_h[15:8] = b;
                if (pos == POS_DEPTH && (b != DEPTH_24 || pixel_base < MIN_OFFSET)) begin
                    rejected_f    = 1'b1;
                    res.event_res = EV_REJECT;
                    res.final_res = 1'b1;
                    hit           = 1'b1;
                end
            end else if (pos >= pixel_base && row_num < img_h) begin
                pix_bytes = 32'(img_w) * 32'd3;
                row_bytes = (pix_bytes + 32'd3) & ~32'd3;
                if (32'(row_pos) < pix_bytes) begin
                    case (rgb_phase)
                        PH_BLUE: begin
                            blue_green[7:0] = b;
                            rgb_phase       = PH_GREEN;
                        end
                        PH_GREEN: begin
                            blue_green[15:8] = b;
                            rgb_phase        = PH_RED;
                        end
                        default: begin
                            res.event_res = EV_PIXEL;
                            res.pixel_x   = 17'(org_x) + 17'(col_num);
                            res.pixel_y   = 17'(org_y) + 17'(img_h) - 17'd1 - 17'(row_num);
                            res.color     = {b[7:3], blue_green[15:10], blue_green[7:3]};
                            hit           = 1'b1;
                            rgb_phase     = PH_BLUE;
                            col_num       = col_num + 16'd1;
                        end
                    endcase
                end
                row_pos = row_pos + 18'd1;
                if (32'(row_pos) >= row_bytes) begin
                    row_pos   = '0;
                    rgb_phase = PH_BLUE;
                    col_num   = '0;
                    row_num   = row_num + 16'd1;
                end
            end
        end
        if (file_pos != '1)
            file_pos = file_pos + 32'd1;
        if (eof) begin
            if (hit) begin
                res.final_res = 1'b1;
            end else if (!rejected_f) begin
                res.event_res = (pos < POS_DEPTH) ? EV_REJECT : EV_END;
                res.final_res = 1'b1;
                hit           = 1'b1;
            end
            restart_file();
        end
        if (hit)
            predicted_pix_beats.push_back(res);
    endtask

    task automatic check_result(input t_pix_beat got);
        t_pix_beat want;
        if (predicted_pix_beats.size() == 0) begin
            $error("unexpected result beat: event_res %0d pixel_x %0d pixel_y %0d color %h",
                   got.event_res, got.pixel_x, got.pixel_y, got.color);
            mismatches++;
            return;
        end
        want = predicted_pix_beats.pop_front();
        if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            mismatches++;
        end
        if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
            mismatches++;
        end
        if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
            mismatches++;
        end
        if (got.color !== want.color) begin
            $error("color: expected %h, got %h", want.color, got.color);
            mismatches++;
        end
        if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x = '0;
            org_y = '0;
            restart_file();
            predicted_pix_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ORIGIN_X)
                    org_x = i_cfg_wdata;
                else if (i_cfg_idx == CFG_ORIGIN_Y)
                    org_y = i_cfg_wdata;
            end
            if (i_byte.valid && i_byte.ready)
                decode_file_byte(i_byte.payload.file_byte, i_byte.payload.end_of_file);
            if (i_pix.valid && i_pix.ready)
                check_result(i_pix.payload);
        end
        o_outstanding <= predicted_pix_beats.size();
        o_mismatches  <= mismatches;
    end

endmodule

// ===== tb/bmp24_stream_to_rgb565_pixels_tb.sv =====
// Top of the BMP decoder testbench: clock, reset, BMP file stimulus, output stalls, verdict.
module bmp24_stream_to_rgb565_pixels_tb;
    import bmp565_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_BYTES = 1000;
    localparam int PHASES       = 5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  steady = 1'b0;
    int                    mismatches;
    int                    outstanding;
    int                    bytes_sent = 0;
    logic [7:0]            file_bytes[$];

    bmp565_byte_if byte_if();
    bmp565_pix_if  pix_if();

    bmp24_stream_to_rgb565_pixels DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_pix       (pix_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    bmp24_stream_to_rgb565_pixels_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (byte_if),
        .i_pix         (pix_if),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic put_byte(input logic [7:0] b, input logic eof);
        while (!steady && $urandom_range(0, 99) < 17) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.payload <= {b, eof};
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // data_len < 0 means every row in full; fill < 0 means random pixel bytes
    task automatic make_bmp(input logic [31:0] offset, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth,
                            input int data_len, input int tail_len, input int fill);
        int pad;
        int row_bytes;
        file_bytes.delete();
        for (int i = 0; i <= 28; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
            file_bytes[10 + i] = offset[8 * i +: 8];
        file_bytes[18] = w[7:0];
        file_bytes[19] = w[15:8];
        file_bytes[22] = h[7:0];
        file_bytes[23] = h[15:8];
        file_bytes[28] = depth;
        pad = (offset >= 29 && offset < 128) ? int'(offset) - 29 : $urandom_range(0, 3);
        repeat (pad) file_bytes.push_back(8'($urandom_range(0, 255)));
        row_bytes = ((int'(w) * 3 + 3) / 4) * 4;
        if (data_len < 0)
            data_len = row_bytes * int'(h);
        repeat (data_len)
            file_bytes.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        repeat (tail_len) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // keep <= 0 sends the whole file; the last byte sent carries end of file
    task automatic send_file(input int keep);
        int n;
        n = (keep > 0 && keep < file_bytes.size()) ? keep : file_bytes.size();
        for (int i = 0; i < n; i++)
            put_byte(file_bytes[i], i == n - 1);
    endtask

    task automatic drain();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_origins(input logic [10:0] x, input logic [10:0] y);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_ORIGIN_X;
        cfg_wdata <= x;
        @(posedge i_clk);
        cfg_idx   <= CFG_ORIGIN_Y;
        cfg_wdata <= y;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_file();
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 78) begin
            make_bmp(29 + $urandom_range(0, 24), 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 4)), DEPTH_24, -1, $urandom_range(0, 4), -1);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(29, file_bytes.size()) : 0;
            send_file(cut);
        end else if (kind < 86) begin
            // wide or tall image, cut off early in the pixel data
            make_bmp(29 + $urandom_range(0, 8), 16'($urandom_range(7, 65535)),
                     16'($urandom_range(1, 65535)), DEPTH_24, $urandom_range(0, 40), 0, -1);
            send_file(0);
        end else begin
            make_bmp(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 40),
                     16'($urandom), 16'($urandom_range(0, 3)),
                     ($urandom_range(0, 1) != 0) ? DEPTH_24 : 8'($urandom),
                     $urandom_range(0, 30), $urandom_range(0, 4), -1);
            send_file($urandom_range(1, file_bytes.size()));
        end
    endtask

    initial begin : receiver
        int got;
        int hold_left;
        got       = 0;
        hold_left = 0;
        pix_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_if.valid && pix_if.ready) begin
                got++;
                if (got == 40 || got == 250)
                    hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_if.ready <= 1'b0;
            end else begin
                pix_if.ready <= steady || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("bmp24_stream_to_rgb565_pixels_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int start;
        i_rst_n         <= 1'b0;
        byte_if.valid   <= 1'b0;
        byte_if.payload <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_ORIGIN_X;
        cfg_wdata       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_origins(11'd0, 11'd0);

        // smallest image, row padding byte ends the file
        make_bmp(29, 1, 1, DEPTH_24, -1, 0, 8'hFF);
        send_file(0);
        // pixel completed by the final byte
        make_bmp(29, 1, 1, DEPTH_24, 3, 0, 8'h00);
        send_file(0);
        make_bmp(54, 2, 2, DEPTH_24, -1, 3, -1);
        send_file(0);
        make_bmp(40, 5, 3, DEPTH_24, -1, 2, -1);
        send_file(0);
        // triple cut off by end of file
        make_bmp(29, 3, 1, DEPTH_24, 5, 0, -1);
        send_file(0);
        // depth other than 24
        make_bmp(54, 2, 2, 8'd32, -1, 2, -1);
        send_file(0);
        make_bmp(54, 2, 1, 8'hFF, -1, 0, -1);
        send_file(0);
        // pixel offset inside the header
        make_bmp(28, 2, 1, DEPTH_24, 6, 0, -1);
        send_file(0);
        make_bmp(0, 1, 1, DEPTH_24, 3, 0, -1);
        send_file(0);
        // header cut short
        make_bmp(54, 1, 1, DEPTH_24, -1, 0, -1);
        send_file(1);
        send_file(20);
        send_file(28);
        send_file(29);
        make_bmp(54, 1, 1, 8'd8, -1, 0, -1);
        send_file(29);
        // empty images
        make_bmp(29, 0, 3, DEPTH_24, 4, 0, -1);
        send_file(0);
        make_bmp(29, 4, 0, DEPTH_24, 8, 0, -1);
        send_file(0);
        // largest sizes, and an offset never reached
        make_bmp(29, 16'hFFFF, 16'hFFFF, DEPTH_24, 12, 0, -1);
        send_file(0);
        make_bmp(32'hFFFF_FFFF, 2, 2, DEPTH_24, 10, 0, -1);
        send_file(0);

        start = bytes_sent;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            steady <= (p == 2);
            case (p)
                0:       set_origins(11'd2047, 11'd2047);
                2:       set_origins(11'd0, 11'd2047);
                3:       set_origins(11'd2047, 11'd0);
                default: set_origins(11'($urandom), 11'($urandom));
            endcase
            while (bytes_sent < start + (p + 1) * RANDOM_BYTES / PHASES)
                random_file();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bmp24_stream_to_rgb565_pixels_tb OK");
        end else begin
            $display("bmp24_stream_to_rgb565_pixels_tb NOT OK");
        end
        $finish;
    end

endmodule
